[hdl/brfo_pkg.sv]
// Shared constants, operation codes and controller/datapath types for the byte ring FIFO.
package brfo_pkg;

    localparam int BRFO_DEPTH     = 256;  // default ring storage depth
    localparam int BRFO_CAP_W     = 9;    // capacity register and fill level width
    localparam int BRFO_CAP_RESET = 256;  // capacity after reset
    localparam int BRFO_MODE_W    = 3;
    localparam int BRFO_BYTE_W    = 8;
    localparam int BRFO_IN_W      = 16;   // input tdata, padded to bytes
    localparam int BRFO_OUT_W     = 24;   // output tdata, padded to bytes

    // Operation codes carried in the mode field
    localparam logic [BRFO_MODE_W-1:0] MODE_WRITE     = 3'd0;
    localparam logic [BRFO_MODE_W-1:0] MODE_OVERWRITE = 3'd1;
    localparam logic [BRFO_MODE_W-1:0] MODE_READ      = 3'd2;
    localparam logic [BRFO_MODE_W-1:0] MODE_PEEK      = 3'd3;
    localparam logic [BRFO_MODE_W-1:0] MODE_FLUSH     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_RESP  = 3'b100
    } brfo_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic cfg_we;     // capacity write this cycle
        logic load_byte;  // capture ram read data into the result
    } brfo_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_fetch; // offered beat is a read or peek on a non-empty ring
    } brfo_stat_t;

endpackage

[hdl/byte_ring_fifo_overwrite.sv]
// Byte FIFO on a ring with refused write, overwrite, pop, peek and flush operations.
// Each beat on s_axis carries one operation and yields exactly one result beat on
// m_axis with the byte read, success, dropped, fill level, full and empty. A result
// is offered in the cycle after its operation is taken; a read or peek of a non-empty
// FIFO passes through a fetch state first, since the slot store is a RAM with registered
// read data. A new operation is taken in the same cycle its predecessor's result is
// taken, so a busy stream runs at one operation per cycle while m_axis does not stall,
// and no new operation is taken during the fetch of a read or peek that finds data.
// Writing the capacity register empties the FIFO; zero acts as one and values above
// DEPTH act as DEPTH. Capacity writes are taken only while no result is pending.
module byte_ring_fifo_overwrite
    import brfo_pkg::*;
#(
    parameter int DEPTH = BRFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BRFO_IN_W-1:0]  s_axis_tdata,  // mode[2:0], write_byte[10:3]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BRFO_OUT_W-1:0] m_axis_tdata,  // read_byte[7:0], success[8], dropped[9],
                                                 // fill_level[18:10], is_full[19], is_empty[20]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BRFO_CAP_W-1:0] cfg_data       // capacity
);

    brfo_cmd_t  cmd;
    brfo_stat_t stat;

    brfo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    brfo_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .cfg_data (cfg_data),
        .out_data (m_axis_tdata)
    );

endmodule

[hdl/brfo_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module brfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/brfo_datapath.sv]
// Ring pointers, fill count, capacity, slot storage and the result register.
module brfo_datapath
    import brfo_pkg::*;
#(
    parameter int DEPTH = BRFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brfo_cmd_t             cmd,
    output brfo_stat_t            stat,
    input  logic [BRFO_IN_W-1:0]  in_data,
    input  logic [BRFO_CAP_W-1:0] cfg_data,
    output logic [BRFO_OUT_W-1:0] out_data
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RST_EFF = (BRFO_CAP_RESET > DEPTH) ? DEPTH : BRFO_CAP_RESET;

    logic [BRFO_MODE_W-1:0] mode;
    logic [BRFO_BYTE_W-1:0] wbyte;

    logic [AW-1:0]         front_reg, front_next;
    logic [AW-1:0]         back_reg, back_next;
    logic [AW-1:0]         last_reg;          // highest slot index of the current capacity
    logic [BRFO_CAP_W-1:0] cnt_reg, cnt_next;
    logic [BRFO_CAP_W-1:0] cap_reg;
    logic [BRFO_CAP_W-1:0] cap_in;

    logic [BRFO_BYTE_W-1:0] rbyte_reg;
    logic                   ok_reg, ok_next;
    logic                   drop_reg, drop_next;
    logic [BRFO_CAP_W-1:0]  fill_reg;
    logic                   full_reg, empty_reg;

    logic full_now, ram_we, ram_re;
    logic [BRFO_BYTE_W-1:0] ram_rdata;

    assign mode  = in_data[BRFO_MODE_W-1:0];
    assign wbyte = in_data[BRFO_MODE_W +: BRFO_BYTE_W];

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                              input logic [AW-1:0] last);
        if (idx == last)
            return '0;
        return AW'(idx + 1'b1);
    endfunction

    assign full_now = (cnt_reg == cap_reg);
    assign stat.need_fetch = (mode inside {MODE_READ, MODE_PEEK}) && (cnt_reg != '0);

    // zero acts as one, anything above the ring depth saturates
    always_comb
    begin
        cap_in = cfg_data;
        if (cfg_data == '0)
            cap_in = BRFO_CAP_W'(1);
        else if (32'(cfg_data) > 32'(DEPTH))
            cap_in = BRFO_CAP_W'(DEPTH);
    end

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        cnt_next   = cnt_reg;
        ok_next    = 1'b0;
        drop_next  = 1'b0;
        ram_we     = 1'b0;
        case (mode)
            MODE_WRITE, MODE_OVERWRITE:
            begin
                if (!full_now || (mode == MODE_OVERWRITE))
                begin
                    ram_we    = 1'b1;
                    back_next = advance(back_reg, last_reg);
                    if (!full_now)
                        cnt_next = BRFO_CAP_W'(cnt_reg + 1'b1);
                    else
                    begin
                        front_next = advance(front_reg, last_reg);
                        drop_next  = 1'b1;
                    end
                    ok_next = 1'b1;
                end
            end
            MODE_READ, MODE_PEEK:
            begin
                if (cnt_reg != '0)
                begin
                    ok_next = 1'b1;
                    if (mode == MODE_READ)
                    begin
                        front_next = advance(front_reg, last_reg);
                        cnt_next   = BRFO_CAP_W'(cnt_reg - 1'b1);
                    end
                end
            end
            MODE_FLUSH:
            begin
                front_next = '0;
                back_next  = '0;
                cnt_next   = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign ram_re = cmd.accept && stat.need_fetch;

    brfo_ram #(
        .WIDTH (BRFO_BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && ram_we),
        .wr_addr (back_reg),
        .wr_data (wbyte),
        .rd_en   (ram_re),
        .rd_addr (front_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            cnt_reg   <= '0;
            cap_reg   <= BRFO_CAP_W'(RST_EFF);
            last_reg  <= AW'(RST_EFF - 1);
        end
        else if (cmd.cfg_we)
        begin
            // a capacity write also empties the ring
            front_reg <= '0;
            back_reg  <= '0;
            cnt_reg   <= '0;
            cap_reg   <= cap_in;
            last_reg  <= AW'(cap_in - 1'b1);
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rbyte_reg <= '0;
            ok_reg    <= ok_next;
            drop_reg  <= drop_next;
            fill_reg  <= cnt_next;
            full_reg  <= (cnt_next == cap_reg);
            empty_reg <= (cnt_next == '0);
        end
        else if (cmd.load_byte)
        begin
            rbyte_reg <= ram_rdata;
        end
    end

    assign out_data = {3'b000, empty_reg, full_reg, fill_reg, drop_reg, ok_reg, rbyte_reg};

endmodule

[hdl/brfo_ctrl.sv]
// Sequencing of input beats, ram fetch, result hand-off and capacity writes.
module brfo_ctrl
    import brfo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  brfo_stat_t stat,
    output brfo_cmd_t  cmd
);

    brfo_state_t state_reg, state_next;

    always_comb
    begin
        in_ready  = ((state_reg == ST_IDLE) && !cfg_valid)
                 || ((state_reg == ST_RESP) && out_ready);
        out_valid = (state_reg == ST_RESP);
        cfg_ready = (state_reg == ST_IDLE);

        cmd.accept    = in_valid && in_ready;
        cmd.cfg_we    = cfg_valid && cfg_ready;
        cmd.load_byte = (state_reg == ST_FETCH);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                    state_next = stat.need_fetch ? ST_FETCH : ST_RESP;
            end
            ST_FETCH:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (cmd.accept)
                    state_next = stat.need_fetch ? ST_FETCH : ST_RESP;
                else if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/brfo_checker.sv]
// Port-level checks for the byte ring FIFO, bound to the top level.
module brfo_checker
    import brfo_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [BRFO_OUT_W-1:0] m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    logic       ok, drop, full, empty;
    logic [7:0] rbyte;
    logic [8:0] fill;

    assign rbyte = m_axis_tdata[7:0];
    assign ok    = m_axis_tdata[8];
    assign drop  = m_axis_tdata[9];
    assign fill  = m_axis_tdata[18:10];
    assign full  = m_axis_tdata[19];
    assign empty = m_axis_tdata[20];

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // an overwrite that drops leaves the FIFO full and reports success
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && drop |-> ok && full && !empty)
        else $error("drop without success or full");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (empty == (fill == 9'd0)))
        else $error("empty flag disagrees with fill level");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (rbyte != 8'd0) |-> ok)
        else $error("nonzero byte on a failed operation");

    // capacity writes never share an edge with an input beat
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("capacity write taken together with an input beat");

endmodule

bind byte_ring_fifo_overwrite brfo_checker u_brfo_checker (.*);

[sim/byte_ring_fifo_overwrite_test.sv]
// Self-checking testbench for byte_ring_fifo_overwrite: capacity sweeps and random FIFO traffic.
module byte_ring_fifo_overwrite_test;
    import brfo_pkg::*;

    // Mode codes the block ignores
    localparam logic [BRFO_MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [BRFO_MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;
    localparam int RESULT_W = 21;
    localparam int PHASES   = 10;

    // Result beat, fields from the top bit down
    typedef struct packed {
        logic                  is_empty;
        logic                  is_full;
        logic [BRFO_CAP_W-1:0] fill_level;
        logic                  dropped;
        logic                  success;
        logic [BRFO_BYTE_W-1:0] read_byte;
    } fifo_result_t;

    class fifo_scoreboard;
        logic [BRFO_BYTE_W-1:0] slots [BRFO_DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned count;
        int unsigned cap_reg;
        fifo_result_t pending[$];
        int unsigned errors;
        int unsigned ops_seen;
        int unsigned drops;
        int unsigned refused;
        int unsigned empty_reads;
        int unsigned full_hits;

        function new();
            set_capacity(BRFO_CAP_RESET);
        endfunction

        // Capacity write also empties the ring
        function void set_capacity(int unsigned value);
            cap_reg = value;
            head = 0;
            tail = 0;
            count = 0;
        endfunction

        function int unsigned usable();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > BRFO_DEPTH)
                return BRFO_DEPTH;
            return cap_reg;
        endfunction

        function int unsigned wrap(int unsigned idx, int unsigned cap);
            return (idx + 1 >= cap) ? 0 : idx + 1;
        endfunction

        function void note_op(logic [BRFO_MODE_W-1:0] mode, logic [BRFO_BYTE_W-1:0] data);
            fifo_result_t r;
            int unsigned cap;
            cap = usable();
            r = '0;
            ops_seen++;
            case (mode)
                MODE_WRITE, MODE_OVERWRITE:
                begin
                    if (count < cap || mode == MODE_OVERWRITE)
                    begin
                        slots[tail] = data;
                        tail = wrap(tail, cap);
                        if (count < cap)
                            count++;
                        else
                        begin
                            head = wrap(head, cap);
                            r.dropped = 1'b1;
                            drops++;
                        end
                        r.success = 1'b1;
                    end
                    else
                        refused++;
                end
                MODE_READ, MODE_PEEK:
                begin
                    if (count > 0)
                    begin
                        r.read_byte = slots[head];
                        if (mode == MODE_READ)
                        begin
                            head = wrap(head, cap);
                            count--;
                        end
                        r.success = 1'b1;
                    end
                    else
                        empty_reads++;
                end
                MODE_FLUSH:
                begin
                    head = 0;
                    tail = 0;
                    count = 0;
                    r.success = 1'b1;
                end
                default:
                    ;
            endcase
            r.fill_level = count[BRFO_CAP_W-1:0];
            r.is_full = (count == cap);
            r.is_empty = (count == 0);
            if (r.is_full)
                full_hits++;
            pending.push_back(r);
        endfunction

        function void check_result(logic [BRFO_OUT_W-1:0] beat);
            fifo_result_t got;
            fifo_result_t want;
            got = fifo_result_t'(beat[RESULT_W-1:0]);
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result beat %h with nothing expected", $time, beat);
                return;
            end
            want = pending.pop_front();
            if (got !== want || beat[BRFO_OUT_W-1:RESULT_W] !== '0)
            begin
                errors++;
                $display("%0t: expected byte %h ok %b drop %b fill %0d full %b empty %b pad 0",
                         $time, want.read_byte, want.success, want.dropped, want.fill_level,
                         want.is_full, want.is_empty);
                $display("%0t:   actual byte %h ok %b drop %b fill %0d full %b empty %b pad %h",
                         $time, got.read_byte, got.success, got.dropped, got.fill_level,
                         got.is_full, got.is_empty, beat[BRFO_OUT_W-1:RESULT_W]);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BRFO_IN_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BRFO_OUT_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [BRFO_CAP_W-1:0]  cfg_data = '0;

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cap_writes = 0;

    fifo_scoreboard sb = new();

    byte_ring_fifo_overwrite dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Result side backpressure in bursts of random length
    always @(negedge clk)
    begin
        if (!sink_idle)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Entered and left at a falling edge; tvalid stays high into the next beat
    task automatic send_op(input logic [BRFO_MODE_W-1:0] mode,
                           input logic [BRFO_BYTE_W-1:0] data);
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(BRFO_IN_W - BRFO_MODE_W - BRFO_BYTE_W){1'b0}}, data, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_op(mode, data);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [BRFO_CAP_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_capacity(value);
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BRFO_MODE_W-1:0] pick_mode(int unsigned wr_pct,
                                                        int unsigned fl_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < wr_pct)
            return ($urandom_range(0, 3) == 0) ? MODE_OVERWRITE : MODE_WRITE;
        if (r < wr_pct + fl_pct)
            return MODE_FLUSH;
        if (r < wr_pct + fl_pct + 2)
            return BRFO_MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        return ($urandom_range(0, 2) == 0) ? MODE_PEEK : MODE_READ;
    endfunction

    initial
    begin
        int unsigned phase_cap [PHASES];
        int unsigned phase_ops [PHASES];
        int unsigned phase_wr [PHASES];
        int unsigned phase_fl [PHASES];

        // First saturated capacity phase is write heavy with no flush so the ring fills to 256
        phase_cap = '{511, 1, 2, 3, 257, 7, 256, $urandom_range(4, 16), 0, 5};
        phase_ops = '{400, 60, 80, 100, 120, 150, 80, 100, 40, 120};
        phase_wr  = '{85, 50, 55, 50, 60, 50, 45, 50, 50, 50};
        phase_fl  = '{0, 3, 3, 3, 2, 3, 3, 3, 3, 2};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset capacity: empty reads, byte extremes, pop order, flush, ignored modes
        send_op(MODE_READ, 8'h5A);
        send_op(MODE_PEEK, 8'hFF);
        send_op(MODE_WRITE, 8'h00);
        send_op(MODE_WRITE, 8'hFF);
        send_op(MODE_PEEK, 8'h00);
        send_op(MODE_READ, 8'h00);
        send_op(MODE_READ, 8'h00);
        send_op(MODE_READ, 8'h00);
        send_op(MODE_OVERWRITE, 8'hA5);
        send_op(MODE_FLUSH, 8'hFF);
        send_op(MODE_PEEK, 8'h00);
        send_op(MODE_UNUSED_FIRST, 8'h00);
        send_op(MODE_UNUSED_FIRST + 1'b1, 8'hFF);
        send_op(MODE_UNUSED_LAST, 8'h81);

        // Zero capacity behaves as one slot: refused write, drop on overwrite
        write_capacity('0);
        send_op(MODE_WRITE, 8'h3C);
        send_op(MODE_WRITE, 8'hC3);
        send_op(MODE_OVERWRITE, 8'h5A);
        send_op(MODE_PEEK, 8'h00);
        send_op(MODE_READ, 8'h00);
        send_op(MODE_READ, 8'h00);
        send_op(MODE_OVERWRITE, 8'h11);
        send_op(MODE_FLUSH, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(BRFO_CAP_W'(phase_cap[p]));
            src_idle = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < phase_ops[p]; i++)
                send_op(pick_mode(phase_wr[p], phase_fl[p]), BRFO_BYTE_W'($urandom));
        end

        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d operations across %0d capacity writes, including zero and above depth.",
                 sb.ops_seen, cap_writes);
        $display("Saw %0d drops, %0d refused writes, %0d empty reads, %0d full results.",
                 sb.drops, sb.refused, sb.empty_reads, sb.full_hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("byte_ring_fifo_overwrite: match");
        else
            $display("byte_ring_fifo_overwrite: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d results outstanding", sb.pending.size());
        $display("byte_ring_fifo_overwrite: mismatch");
        $finish;
    end

endmodule
